### design/owtsm_pkg.sv
// ----------------------------------------------------------------------------
// owtsm_pkg: shared types and constants for the 1-Wire temperature master
// Word types, configuration register map, status codes and delay loading.
// ----------------------------------------------------------------------------
`default_nettype none

package owtsm_pkg;

    // Delay counter width and limit
    localparam int DELAY_BITS = 10;
    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    // Configuration register widths
    localparam int CFG_WIDE_W  = 10;
    localparam int CFG_SLOT_W  = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int LOAD_W      = (DELAY_BITS > CFG_WIDE_W) ? DELAY_BITS : CFG_WIDE_W;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_WAIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AFTER_PRESENCE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE    = 3'd4;

    // Request kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_CONVERT = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // Completion status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NO_PRESENCE = 2'd1;
    localparam logic [1:0] STATUS_ALL_ONES    = 2'd2;

    // ROM and function commands
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

    typedef struct packed {
        logic [1:0] kind;
        logic       bus_level;
    } in_word_t;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic [1:0]         status;
        logic signed [15:0] temperature;
    } out_word_t;

    typedef struct packed {
        logic [CFG_WIDE_W-1:0] reset_low_us;
        logic [CFG_WIDE_W-1:0] presence_wait_us;
        logic [CFG_WIDE_W-1:0] after_presence_us;
        logic [CFG_SLOT_W-1:0] slot_us;
        logic [CFG_SLOT_W-1:0] read_sample_us;
    } cfg_t;

    // Zero counts as one tick, values above the counter range saturate
    function automatic logic [DELAY_BITS-1:0] load_delay(input logic [CFG_WIDE_W-1:0] v);
        logic [LOAD_W-1:0] wide_v;
        wide_v = LOAD_W'(v);
        if (v == '0)
            return DELAY_BITS'(1);
        else if (wide_v > LOAD_W'(DELAY_MAX))
            return DELAY_MAX;
        else
            return DELAY_BITS'(wide_v);
    endfunction

endpackage

`default_nettype wire

### design/owtsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owtsm_cfg_regs: timing register file
// Holds the five bus timing registers, written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module owtsm_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [owtsm_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [owtsm_pkg::CFG_WIDE_W-1:0]  wr_data,
    output owtsm_pkg::cfg_t                     cfg
);
    import owtsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the written register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_RESET_LOW:      cfg_next.reset_low_us      = wr_data;
                CFG_PRESENCE_WAIT:  cfg_next.presence_wait_us  = wr_data;
                CFG_AFTER_PRESENCE: cfg_next.after_presence_us = wr_data;
                CFG_SLOT:           cfg_next.slot_us           = wr_data[CFG_SLOT_W-1:0];
                CFG_READ_SAMPLE:    cfg_next.read_sample_us    = wr_data[CFG_SLOT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load defaults at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us      <= CFG_WIDE_W'(480);
            cfg_reg.presence_wait_us  <= CFG_WIDE_W'(70);
            cfg_reg.after_presence_us <= CFG_WIDE_W'(410);
            cfg_reg.slot_us           <= CFG_SLOT_W'(60);
            cfg_reg.read_sample_us    <= CFG_SLOT_W'(10);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/owtsm_seq.sv
// ----------------------------------------------------------------------------
// owtsm_seq: 1-Wire command sequencer
// Advances reset, presence, write slot and read slot timing by one tick per
// word and forms the result word for that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module owtsm_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_en,
    input  wire owtsm_pkg::in_word_t  in_word,
    input  wire owtsm_pkg::cfg_t      cfg,
    output owtsm_pkg::out_word_t      result
);
    import owtsm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL,
        PH_W_START, PH_W_SLOT, PH_W_REC,
        PH_R_START, PH_R_WAIT, PH_R_TAIL
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    logic [2:0]            bit_reg, bit_next;
    logic [1:0]            byte_reg, byte_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            low_reg, low_next;
    logic                  is_read_reg, is_read_next;
    logic [15:0]           temp_reg, temp_next;

    logic                  drive;
    logic                  done;
    logic [1:0]            status;
    logic                  tick_end;
    logic                  end_bit;
    logic [7:0]            cmd_byte;
    logic [CFG_SLOT_W-1:0] tail_len;

    // Step the sequencer by one tick
    always_comb
    begin
        phase_next   = phase_reg;
        delay_next   = delay_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        low_next     = low_reg;
        is_read_next = is_read_reg;
        temp_next    = temp_reg;
        drive        = 1'b0;
        done         = 1'b0;
        status       = STATUS_OK;
        end_bit      = 1'b0;
        tail_len     = cfg.slot_us - cfg.read_sample_us;

        // Start a command on an idle tick
        if (phase_reg == PH_IDLE &&
            (in_word.kind == KIND_CONVERT || in_word.kind == KIND_READ))
        begin
            phase_next   = PH_RST_LOW;
            delay_next   = load_delay(cfg.reset_low_us);
            is_read_next = (in_word.kind == KIND_READ);
            bit_next     = '0;
            byte_next    = '0;
            shift_next   = '0;
        end

        cmd_byte = (byte_next == 2'd0) ? CMD_SKIP_ROM
                 : (is_read_next ? CMD_READ_PAD : CMD_CONVERT);

        // Count down the timed phase
        tick_end = (delay_next <= DELAY_BITS'(1));

        unique case (phase_next)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_RST_LOW:
            begin
                drive = 1'b1;
                if (tick_end)
                begin
                    phase_next = PH_RST_WAIT;
                    delay_next = load_delay(cfg.presence_wait_us);
                end
                else
                    delay_next = delay_next - DELAY_BITS'(1);
            end
            PH_RST_WAIT:
            begin
                if (tick_end)
                begin
                    if (in_word.bus_level)
                    begin
                        phase_next = PH_IDLE;
                        delay_next = '0;
                        done       = 1'b1;
                        status     = STATUS_NO_PRESENCE;
                    end
                    else
                    begin
                        phase_next = PH_RST_TAIL;
                        delay_next = load_delay(cfg.after_presence_us);
                    end
                end
                else
                    delay_next = delay_next - DELAY_BITS'(1);
            end
            PH_RST_TAIL:
            begin
                if (tick_end)
                begin
                    delay_next = '0;
                    phase_next = PH_W_START;
                    bit_next   = '0;
                    byte_next  = '0;
                end
                else
                    delay_next = delay_next - DELAY_BITS'(1);
            end
            PH_W_START:
            begin
                drive      = 1'b1;
                phase_next = PH_W_SLOT;
                delay_next = load_delay(CFG_WIDE_W'(cfg.slot_us));
            end
            PH_W_SLOT:
            begin
                drive = !cmd_byte[bit_next];
                if (tick_end)
                begin
                    delay_next = '0;
                    phase_next = PH_W_REC;
                end
                else
                    delay_next = delay_next - DELAY_BITS'(1);
            end
            PH_W_REC:
            begin
                if (bit_next != 3'd7)
                begin
                    bit_next   = bit_next + 3'd1;
                    phase_next = PH_W_START;
                end
                else
                begin
                    bit_next = '0;
                    if (byte_next == 2'd0)
                    begin
                        byte_next  = 2'd1;
                        phase_next = PH_W_START;
                    end
                    else if (!is_read_next)
                    begin
                        phase_next = PH_IDLE;
                        delay_next = '0;
                        done       = 1'b1;
                        status     = STATUS_OK;
                    end
                    else
                    begin
                        byte_next  = '0;
                        shift_next = '0;
                        phase_next = PH_R_START;
                    end
                end
            end
            PH_R_START:
            begin
                drive      = 1'b1;
                phase_next = PH_R_WAIT;
                delay_next = load_delay(CFG_WIDE_W'(cfg.read_sample_us));
            end
            PH_R_WAIT:
            begin
                if (tick_end)
                begin
                    delay_next = '0;
                    shift_next[bit_next] = shift_next[bit_next] | in_word.bus_level;
                    if (cfg.slot_us > cfg.read_sample_us)
                    begin
                        phase_next = PH_R_TAIL;
                        delay_next = load_delay(CFG_WIDE_W'(tail_len));
                    end
                    else
                        end_bit = 1'b1;
                end
                else
                    delay_next = delay_next - DELAY_BITS'(1);
            end
            PH_R_TAIL:
            begin
                if (tick_end)
                begin
                    delay_next = '0;
                    end_bit    = 1'b1;
                end
                else
                    delay_next = delay_next - DELAY_BITS'(1);
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Close a read bit: next bit, next byte, or finish the read
        if (end_bit)
        begin
            if (bit_next != 3'd7)
            begin
                bit_next   = bit_next + 3'd1;
                phase_next = PH_R_START;
            end
            else
            begin
                bit_next = '0;
                if (byte_next == 2'd0)
                begin
                    low_next   = shift_next;
                    shift_next = '0;
                    byte_next  = 2'd1;
                    phase_next = PH_R_START;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    done       = 1'b1;
                    if (low_next == BYTE_ALL_ONES && shift_next == BYTE_ALL_ONES)
                        status = STATUS_ALL_ONES;
                    else
                    begin
                        temp_next = {shift_next, low_next};
                        status    = STATUS_OK;
                    end
                end
            end
        end
    end

    // Hold sequencer state, advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            delay_reg   <= '0;
            bit_reg     <= '0;
            byte_reg    <= '0;
            shift_reg   <= '0;
            low_reg     <= '0;
            is_read_reg <= 1'b0;
            temp_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            delay_reg   <= delay_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shift_reg   <= shift_next;
            low_reg     <= low_next;
            is_read_reg <= is_read_next;
            temp_reg    <= temp_next;
        end
    end

    // Form the result word for this tick
    always_comb
    begin
        result.drive_low   = drive;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.status      = status;
        result.temperature = temp_next;
    end

endmodule

`default_nettype wire

### design/onewire_temp_sensor_master_core.sv
// ----------------------------------------------------------------------------
// onewire_temp_sensor_master_core: 1-Wire master for one temperature sensor
// Runs reset/presence, skip ROM and convert or read scratchpad, one tick
// per input word, and returns one result word per tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | in        | in_valid / in_ready    | in_data  (kind, bus_level)
//  out     | out       | out_valid / out_ready  | out_data (drive_low, busy_res,
//          |           |                        |   done_res, status, temperature)
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input word per clock while the output is not stalled; its result sits in
// the output register on the next cycle. The sequencer state update is the only
// path per word. A new word is taken while the output register is empty or being
// drained, so a stalled consumer stalls the input one for one.
// Reset clears the sequencer, loads default timings and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_temp_sensor_master_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire owtsm_pkg::in_word_t               in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output owtsm_pkg::out_word_t                   out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [owtsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [owtsm_pkg::CFG_WIDE_W-1:0]  cfg_data
);
    import owtsm_pkg::*;

    cfg_t      cfg;
    out_word_t result;
    out_word_t out_data_reg;
    logic      out_valid_reg, out_valid_next;
    logic      in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    owtsm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    owtsm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (in_accept),
        .in_word (in_data),
        .cfg     (cfg),
        .result  (result)
    );

    // Fill on accept, drop when taken
    assign out_valid_next = in_accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("done with busy still set");

    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_OK |-> out_data.done_res)
        else $error("error status without done");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: 1-Wire temperature master core
// Streams bus ticks through the core and compares each result word with a
// cycle-free model of the sequencer. Command sequences are built from the
// current timings so that presence and read samples land on planned ticks;
// the run covers minimum, zero, read sample at the slot and random timings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import owtsm_pkg::*;

    localparam int          CYCLE_LIMIT     = 1_200_000;
    localparam int          RANDOM_ITEMS    = 200;
    localparam int          PHASE_ITEMS     = 100;
    localparam int          HOLD_CYCLES     = 150;
    localparam int          FAIL_PRINTS     = 20;
    localparam logic [1:0]  KIND_SPARE      = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef enum logic [3:0] {
        BP_IDLE, BP_RST_LOW, BP_RST_WAIT, BP_RST_TAIL,
        BP_W_START, BP_W_SLOT, BP_W_REC,
        BP_R_START, BP_R_WAIT, BP_R_TAIL
    } bus_phase_e;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    in_word_t                in_data   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    out_word_t               out_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_WIDE_W-1:0]   cfg_data  = '0;

    // Model copy of timings and sequencer state
    cfg_t        timing = '{reset_low_us: 10'd480, presence_wait_us: 10'd70,
                            after_presence_us: 10'd410, slot_us: 8'd60,
                            read_sample_us: 8'd10};
    bus_phase_e  ph         = BP_IDLE;
    logic [9:0]  ticks_left = '0;
    logic [2:0]  bit_no     = '0;
    logic        byte_no    = 1'b0;
    logic [7:0]  rx_byte    = '0;
    logic [7:0]  rx_low     = '0;
    logic        want_read  = 1'b0;
    logic [15:0] last_temp  = '0;
    logic        tick_done;
    logic [1:0]  tick_status;

    in_word_t    pending_words[$];
    out_word_t   expected_ticks[$];

    int in_gap = 0, out_gap = 0, hold_left = 0;
    bit in_burst = 1'b0, out_burst = 1'b0;
    int holdoffs = 0, next_hold_at = 20;
    int queued_items = 0, checked_ticks = 0, fail_count = 0, cycles = 0;
    int settings_seen = 0, done_ok = 0, done_absent = 0, done_ones = 0;

    onewire_temp_sensor_master_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------

    function automatic logic [9:0] span(input logic [9:0] v);
        return (v == '0) ? 10'd1 : v;
    endfunction

    // Count one tick of a timed phase; true on its last tick
    function automatic bit expire();
        if (ticks_left <= 10'd1)
        begin
            ticks_left = '0;
            return 1'b1;
        end
        ticks_left--;
        return 1'b0;
    endfunction

    function automatic void complete(input logic [1:0] st);
        ph          = BP_IDLE;
        ticks_left  = '0;
        tick_done   = 1'b1;
        tick_status = st;
    endfunction

    function automatic void close_read_bit();
        if (bit_no != 3'd7)
        begin
            bit_no++;
            ph = BP_R_START;
        end
        else
        begin
            bit_no = '0;
            if (!byte_no)
            begin
                rx_low  = rx_byte;
                rx_byte = '0;
                byte_no = 1'b1;
                ph      = BP_R_START;
            end
            else if (rx_low == BYTE_ALL_ONES && rx_byte == BYTE_ALL_ONES)
                complete(STATUS_ALL_ONES);
            else
            begin
                last_temp = {rx_byte, rx_low};
                complete(STATUS_OK);
            end
        end
    endfunction

    function automatic out_word_t predict_tick(input in_word_t w);
        out_word_t  r;
        logic       drive;
        logic [7:0] cmd;
        drive       = 1'b0;
        tick_done   = 1'b0;
        tick_status = STATUS_OK;

        // Take a request only when idle; it is the first reset tick
        if (ph == BP_IDLE && (w.kind == KIND_CONVERT || w.kind == KIND_READ))
        begin
            ph         = BP_RST_LOW;
            ticks_left = span(timing.reset_low_us);
            want_read  = (w.kind == KIND_READ);
            bit_no     = '0;
            byte_no    = 1'b0;
            rx_byte    = '0;
        end

        case (ph)
            BP_RST_LOW:
            begin
                drive = 1'b1;
                if (expire())
                begin
                    ph         = BP_RST_WAIT;
                    ticks_left = span(timing.presence_wait_us);
                end
            end
            BP_RST_WAIT:
            begin
                if (expire())
                begin
                    if (w.bus_level)
                        complete(STATUS_NO_PRESENCE);
                    else
                    begin
                        ph         = BP_RST_TAIL;
                        ticks_left = span(timing.after_presence_us);
                    end
                end
            end
            BP_RST_TAIL:
            begin
                if (expire())
                begin
                    ph      = BP_W_START;
                    bit_no  = '0;
                    byte_no = 1'b0;
                end
            end
            BP_W_START:
            begin
                drive      = 1'b1;
                ph         = BP_W_SLOT;
                ticks_left = span(10'(timing.slot_us));
            end
            BP_W_SLOT:
            begin
                cmd   = !byte_no ? CMD_SKIP_ROM : (want_read ? CMD_READ_PAD : CMD_CONVERT);
                drive = !cmd[bit_no];
                if (expire())
                    ph = BP_W_REC;
            end
            BP_W_REC:
            begin
                if (bit_no != 3'd7)
                begin
                    bit_no++;
                    ph = BP_W_START;
                end
                else
                begin
                    bit_no = '0;
                    if (!byte_no)
                    begin
                        byte_no = 1'b1;
                        ph      = BP_W_START;
                    end
                    else if (!want_read)
                        complete(STATUS_OK);
                    else
                    begin
                        byte_no = 1'b0;
                        rx_byte = '0;
                        ph      = BP_R_START;
                    end
                end
            end
            BP_R_START:
            begin
                drive      = 1'b1;
                ph         = BP_R_WAIT;
                ticks_left = span(10'(timing.read_sample_us));
            end
            BP_R_WAIT:
            begin
                if (expire())
                begin
                    rx_byte[bit_no] = w.bus_level;
                    if (timing.slot_us > timing.read_sample_us)
                    begin
                        ph         = BP_R_TAIL;
                        ticks_left = span(10'(timing.slot_us - timing.read_sample_us));
                    end
                    else
                        close_read_bit();
                end
            end
            BP_R_TAIL:
            begin
                if (expire())
                    close_read_bit();
            end
            default:
                ph = BP_IDLE;
        endcase

        r.drive_low   = drive;
        r.busy_res    = (ph != BP_IDLE);
        r.done_res    = tick_done;
        r.status      = tick_status;
        r.temperature = last_temp;
        return r;
    endfunction

    function automatic void apply_timing(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_WIDE_W-1:0] value);
        case (idx)
            CFG_RESET_LOW:      timing.reset_low_us      = value;
            CFG_PRESENCE_WAIT:  timing.presence_wait_us  = value;
            CFG_AFTER_PRESENCE: timing.after_presence_us = value;
            CFG_SLOT:           timing.slot_us           = value[CFG_SLOT_W-1:0];
            CFG_READ_SAMPLE:    timing.read_sample_us    = value[CFG_SLOT_W-1:0];
            default:            ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Tick offsets of a command under the current timings
    function automatic void command_plan(output int presence_at, output int write_end,
                                         output int slot_len, output int read_at);
        int head;
        head        = int'(span(timing.reset_low_us)) + int'(span(timing.presence_wait_us));
        presence_at = head - 1;
        write_end   = head + int'(span(timing.after_presence_us))
                    + 16 * (int'(span(10'(timing.slot_us))) + 2);
        read_at     = int'(span(10'(timing.read_sample_us)));
        slot_len    = 1 + read_at;
        if (timing.slot_us > timing.read_sample_us)
            slot_len += int'(span(10'(timing.slot_us - timing.read_sample_us)));
    endfunction

    function automatic void offer(input in_word_t w);
        pending_words.push_back(w);
        queued_items++;
    endfunction

    // Queue one command with idle filler; the device answers as planned
    function automatic void queue_command(input logic [1:0] req, input bit present,
                                          input logic [15:0] data);
        int       presence_at, write_end, slot_len, read_at, total, k;
        in_word_t w;
        command_plan(presence_at, write_end, slot_len, read_at);
        if (!present)
            total = presence_at + 1;
        else if (req == KIND_READ)
            total = write_end + 16 * slot_len;
        else
            total = write_end;
        for (int i = 0; i < total; i++)
        begin
            // Throw in requests while busy now and then
            w.kind      = ($urandom_range(0, 7) == 0) ?
                          2'($urandom_range(KIND_TICK, KIND_SPARE)) : KIND_TICK;
            w.bus_level = 1'($urandom_range(0, 1));
            if (i == 0)
                w.kind = req;
            if (i == presence_at)
                w.bus_level = !present;
            if (present && req == KIND_READ && i >= write_end
                && (i - write_end) % slot_len == read_at)
            begin
                k           = (i - write_end) / slot_len;
                w.bus_level = data[k];
            end
            offer(w);
        end
        repeat ($urandom_range(0, 3))
        begin
            w.kind      = $urandom_range(0, 1) ? KIND_SPARE : KIND_TICK;
            w.bus_level = 1'($urandom_range(0, 1));
            offer(w);
        end
    endfunction

    function automatic void queue_random_sequence();
        int          pick, presence_at, write_end, slot_len, read_at;
        in_word_t    w;
        logic [15:0] data;
        pick = $urandom_range(0, 9);
        data = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        if (pick == 0)
        begin
            // Unplanned words, then enough plain ticks to settle
            repeat ($urandom_range(1, 8))
            begin
                w.kind      = 2'($urandom_range(KIND_TICK, KIND_SPARE));
                w.bus_level = 1'($urandom_range(0, 1));
                offer(w);
            end
            command_plan(presence_at, write_end, slot_len, read_at);
            repeat (write_end + 16 * slot_len + 2)
            begin
                w.kind      = KIND_TICK;
                w.bus_level = 1'($urandom_range(0, 1));
                offer(w);
            end
        end
        else if (pick <= 2)
            queue_command($urandom_range(0, 1) ? KIND_READ : KIND_CONVERT, 1'b0, data);
        else if (pick <= 4)
            queue_command(KIND_CONVERT, 1'b1, data);
        else
            queue_command(KIND_READ, 1'b1, data);
    endfunction

    // ------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_WIDE_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_timing(idx, value);
    endtask

    task automatic set_timings(input logic [CFG_WIDE_W-1:0] rst_low,
                               input logic [CFG_WIDE_W-1:0] presence,
                               input logic [CFG_WIDE_W-1:0] after,
                               input logic [CFG_WIDE_W-1:0] slot,
                               input logic [CFG_WIDE_W-1:0] read_at);
        write_reg(CFG_RESET_LOW, rst_low);
        write_reg(CFG_PRESENCE_WAIT, presence);
        write_reg(CFG_AFTER_PRESENCE, after);
        write_reg(CFG_SLOT, slot);
        write_reg(CFG_READ_SAMPLE, read_at);
        // Unmapped indexes must be ignored
        write_reg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 10'($urandom));
        settings_seen++;
        @(negedge clk);
    endtask

    // Wait until every queued word is in and every result is out
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: offer queued words, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_ticks.push_back(predict_tick(in_data));
            if (!in_valid || in_ready)
            begin
                if ($urandom_range(0, 63) == 0)
                    in_burst = !in_burst;
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_words.pop_front();
                    in_gap    = in_burst ? 0 : $urandom_range(0, 6);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: stall at random, hold off once in a while, check
    // ------------------------------------------------------------------

    function automatic void check_field(input string label, input int want, input int got);
        if (want != got)
        begin
            if (fail_count < FAIL_PRINTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_ticks.size() == 0)
                begin
                    if (fail_count < FAIL_PRINTS)
                        $display("%0t: result word with nothing expected, got %h",
                                 $time, out_data);
                    fail_count++;
                end
                else
                begin
                    out_word_t want;
                    want = expected_ticks.pop_front();
                    check_field("drive_low", int'(want.drive_low), int'(out_data.drive_low));
                    check_field("busy_res", int'(want.busy_res), int'(out_data.busy_res));
                    check_field("done_res", int'(want.done_res), int'(out_data.done_res));
                    check_field("status", int'(want.status), int'(out_data.status));
                    check_field("temperature", int'(want.temperature),
                                int'(out_data.temperature));
                    if (want.done_res)
                    begin
                        if (want.status == STATUS_OK)
                            done_ok++;
                        else if (want.status == STATUS_NO_PRESENCE)
                            done_absent++;
                        else
                            done_ones++;
                    end
                end
                checked_ticks++;
                if ($urandom_range(0, 63) == 0)
                    out_burst = !out_burst;
                out_gap = out_burst ? 0 : $urandom_range(0, 6);
            end

            // Hold off long enough for the core to back up its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holdoffs < 2 && checked_ticks >= next_hold_at
                     && pending_words.size() >= 40)
            begin
                hold_left     = HOLD_CYCLES;
                holdoffs++;
                next_hold_at  = checked_ticks + 2000;
                out_ready    <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("onewire_temp_sensor_master_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase_start;
        int slot_pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Shortest legal timings: every command outcome and data extremes
        set_timings(10'd1, 10'd1, 10'd1, 10'd2, 10'd1);
        queue_command(KIND_CONVERT, 1'b1, 16'h0000);
        queue_command(KIND_READ, 1'b1, 16'hFFFF);
        queue_command(KIND_READ, 1'b1, 16'h8000);
        queue_command(KIND_CONVERT, 1'b0, 16'h0000);
        queue_command(KIND_READ, 1'b0, 16'h0000);
        drain();

        // Zero registers count as one tick
        set_timings(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        queue_command(KIND_READ, 1'b1, 16'($urandom));
        queue_command(KIND_READ, 1'b0, 16'h0000);
        drain();

        // Read sample at the slot: no tail
        set_timings(10'd1, 10'd1, 10'd1, 10'd2, 10'd2);
        queue_command(KIND_READ, 1'b1, 16'($urandom));
        drain();

        // Random short timings with random command mixes
        phase_start = queued_items;
        while (queued_items - phase_start < RANDOM_ITEMS)
        begin
            slot_pick = $urandom_range(2, 6);
            set_timings(10'($urandom_range(0, 4)), 10'($urandom_range(0, 4)),
                        10'($urandom_range(0, 4)),
                        {2'($urandom_range(0, 3)), 8'(slot_pick)},
                        {2'($urandom_range(0, 3)), 8'($urandom_range(1, slot_pick + 1))});
            begin
                int start_here;
                start_here = queued_items;
                while (queued_items - start_here < PHASE_ITEMS)
                    queue_random_sequence();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d tick words over %0d timing settings, %0d forced input stalls",
                 checked_ticks, settings_seen, holdoffs);
        $display("Commands finished: %0d ok, %0d without presence, %0d all-ones reads",
                 done_ok, done_absent, done_ones);
        if (fail_count == 0)
            $display("onewire_temp_sensor_master_core verification clean");
        else
            $display("onewire_temp_sensor_master_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
